FILE: rtl/core/spq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// spq_pkg
// shared types and constants for the sorted priority queue
// ---------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH     = 16;
   localparam int PRIO_BITS = 16;
   localparam int TAG_BITS  = 16;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   // fixed widths of the external fields
   localparam int PRIO_PORT_BITS = 16;
   localparam int TAG_PORT_BITS  = 16;
   localparam int OCC_PORT_BITS  = 5;
   localparam int STATUS_BITS    = 2;

   typedef enum logic {
      FUNC_INSERT  = 1'b0,
      FUNC_CONSUME = 1'b1
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // control broadcast to every cell
   typedef struct packed {
      logic                 insert_en;
      logic                 consume_en;
      logic [PRIO_BITS-1:0] new_prio;
      logic [TAG_BITS-1:0]  new_tag;
   } cell_ctrl_type;

endpackage : spq_pkg
`default_nettype wire

FILE: rtl/core/spq_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, compares against the new
// priority and shifts towards either neighbour
// ---------------------------------------------------------------------------
module spq_cell (
   input  wire logic                            clock,
   input  wire spq_pkg::cell_ctrl_type          ctrl,
   input  wire logic                            occupied,
   input  wire logic                            at_tail,
   input  wire logic                            left_cmp,
   input  wire logic [spq_pkg::PRIO_BITS-1:0]   left_prio,
   input  wire logic [spq_pkg::TAG_BITS-1:0]    left_tag,
   input  wire logic [spq_pkg::PRIO_BITS-1:0]   right_prio,
   input  wire logic [spq_pkg::TAG_BITS-1:0]    right_tag,
   output logic                                 cmp,
   output logic [spq_pkg::PRIO_BITS-1:0]        prio,
   output logic [spq_pkg::TAG_BITS-1:0]         tag
);

   logic [spq_pkg::PRIO_BITS-1:0] prio_ff, prio_in;
   logic [spq_pkg::TAG_BITS-1:0]  tag_ff, tag_in;

   // new entry goes ahead of the first stored entry of lower or equal priority
   assign cmp = occupied && (prio_ff <= ctrl.new_prio);

   always_comb begin
      prio_in = prio_ff;
      tag_in  = tag_ff;
      if (ctrl.insert_en) begin
         if (left_cmp) begin
            prio_in = left_prio;
            tag_in  = left_tag;
         end else if (cmp || at_tail) begin
            prio_in = ctrl.new_prio;
            tag_in  = ctrl.new_tag;
         end
      end else if (ctrl.consume_en) begin
         prio_in = right_prio;
         tag_in  = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      tag_ff  <= tag_in;
   end

   assign prio = prio_ff;
   assign tag  = tag_ff;

endmodule : spq_cell
`default_nettype wire

FILE: rtl/core/sorted_priority_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue kept in descending order in a chain of cells
// ---------------------------------------------------------------------------
//  channel   | ports                         | handshake
//  ----------+-------------------------------+-------------------------------
//  request   | req_func/priority_req/payload | start high and busy low
//  response  | rsp_status/out_*/occupancy    | rsp_valid strobe, one cycle
//
//  every request beat is handled at once: all cells compare against the
//  new priority at once and shift in the same clock edge, so busy stays low
//  and a request may be taken on every cycle
//  the response beat appears on the cycle after the request beat
//  reset clears the fill count and the response strobe; cell contents are
//  never read beyond the fill count, so they need no clearing
//  the receiver cannot stall; each response is shown for one cycle only
// ---------------------------------------------------------------------------
module sorted_priority_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_func,
   input  wire logic [15:0] req_priority_req,
   input  wire logic [15:0] req_payload,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_out_priority,
   output logic [15:0]      rsp_out_payload,
   output logic [4:0]       rsp_occupancy
);

   localparam int DEPTH  = spq_pkg::DEPTH;
   localparam int PB     = spq_pkg::PRIO_BITS;
   localparam int TB     = spq_pkg::TAG_BITS;
   localparam int CB     = spq_pkg::CNT_BITS;
   localparam int PPB    = spq_pkg::PRIO_PORT_BITS;
   localparam int TPB    = spq_pkg::TAG_PORT_BITS;
   localparam int OPB    = spq_pkg::OCC_PORT_BITS;

   // fill count and response registers
   logic [CB-1:0]              count_ff, count_in;
   logic                       valid_ff;
   spq_pkg::status_type        status_ff, status_in;
   logic [PB-1:0]              oprio_ff, oprio_in;
   logic [TB-1:0]              otag_ff, otag_in;

   logic                       accept;
   logic                       full;
   logic                       empty;
   spq_pkg::func_type          func;
   spq_pkg::cell_ctrl_type     ctrl;

   // width adaptation between port fields and internal widths
   logic [PPB+PB-1:0]          prio_ext_in;
   logic [TPB+TB-1:0]          tag_ext_in;
   logic [PPB+PB-1:0]          prio_ext_out;
   logic [TPB+TB-1:0]          tag_ext_out;
   logic [OPB+CB-1:0]          occ_ext;

   // chain wiring
   logic [DEPTH-1:0]           occupied;
   logic [DEPTH-1:0]           at_tail;
   logic [DEPTH-1:0]           cmp;
   logic [PB-1:0]              prio   [DEPTH];
   logic [TB-1:0]              tag    [DEPTH];

   // every beat completes without stalling, so busy is tied low
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign func   = spq_pkg::func_type'(req_func);
   assign full   = (count_ff == CB'(DEPTH));
   assign empty  = (count_ff == '0);

   assign prio_ext_in = {{PB{1'b0}}, req_priority_req};
   assign tag_ext_in  = {{TB{1'b0}}, req_payload};

   assign ctrl.insert_en  = accept && (func == spq_pkg::FUNC_INSERT) && !full;
   assign ctrl.consume_en = accept && (func == spq_pkg::FUNC_CONSUME) && !empty;
   assign ctrl.new_prio   = prio_ext_in[PB-1:0];
   assign ctrl.new_tag    = tag_ext_in[TB-1:0];

   // slot flags from the fill count
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_flags
         assign occupied[gi] = (CB'(gi) < count_ff);
         assign at_tail[gi]  = (CB'(gi) == count_ff);
      end
   endgenerate

   // the chain of cells; head at index zero
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic          l_cmp;
         logic [PB-1:0] l_prio;
         logic [TB-1:0] l_tag;
         logic [PB-1:0] r_prio;
         logic [TB-1:0] r_tag;

         if (gi == 0) begin : g_head
            assign l_cmp  = 1'b0;
            assign l_prio = '0;
            assign l_tag  = '0;
         end else begin : g_mid
            assign l_cmp  = cmp[gi-1];
            assign l_prio = prio[gi-1];
            assign l_tag  = tag[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_last
            assign r_prio = '0;
            assign r_tag  = '0;
         end else begin : g_inner
            assign r_prio = prio[gi+1];
            assign r_tag  = tag[gi+1];
         end

         spq_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (occupied[gi]),
            .at_tail    (at_tail[gi]),
            .left_cmp   (l_cmp),
            .left_prio  (l_prio),
            .left_tag   (l_tag),
            .right_prio (r_prio),
            .right_tag  (r_tag),
            .cmp        (cmp[gi]),
            .prio       (prio[gi]),
            .tag        (tag[gi])
         );
      end
   endgenerate

   // fill count and response contents
   always_comb begin
      count_in  = count_ff;
      status_in = spq_pkg::ST_OK;
      oprio_in  = '0;
      otag_in   = '0;
      if (accept) begin
         unique case (func)
            spq_pkg::FUNC_INSERT: begin
               if (full) begin
                  status_in = spq_pkg::ST_FULL;
               end else begin
                  count_in = count_ff + CB'(1);
               end
            end
            spq_pkg::FUNC_CONSUME: begin
               if (empty) begin
                  status_in = spq_pkg::ST_EMPTY;
               end else begin
                  count_in = count_ff - CB'(1);
                  oprio_in = prio[0];
                  otag_in  = tag[0];
               end
            end
            default: begin
               status_in = spq_pkg::ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= accept;
      end
   end

   // response payload needs no reset
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      oprio_ff  <= oprio_in;
      otag_ff   <= otag_in;
   end

   assign prio_ext_out = {{PPB{1'b0}}, oprio_ff};
   assign tag_ext_out  = {{TPB{1'b0}}, otag_ff};
   assign occ_ext      = {{OPB{1'b0}}, count_ff};

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_priority = prio_ext_out[PPB-1:0];
   assign rsp_out_payload  = tag_ext_out[TPB-1:0];
   assign rsp_occupancy    = occ_ext[OPB-1:0];

endmodule : sorted_priority_queue
`default_nettype wire
